FILE: hdl/tdfa_pkg.sv
// Shared types and constants for the table-driven longest-match scanner.
package tdfa_pkg;

	localparam int NUM_STATES  = 16;
	localparam int NUM_SYMBOLS = 128;
	localparam int MAX_LEN     = 256;

	localparam int CMD_W = 2;
	localparam int ROW_W = 4;
	localparam int SYM_W = 7;
	localparam int VAL_W = 5;
	localparam int POS_W = 9;
	localparam int LIM_W = 8;

	localparam int TBL_DEPTH = NUM_STATES * NUM_SYMBOLS;
	localparam int TBL_AW    = ROW_W + SYM_W;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 16;

	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CHAR  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_START = 2'd2;

	// Column-0 value that marks a state as accepting
	localparam logic [VAL_W-1:0] ACCEPT_MARK = 5'd1;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_CHAR,
		OP_START
	} op_kind_t;

	typedef struct packed {
		op_kind_t          kind;
		logic [SYM_W-1:0]  code;
		logic [ROW_W-1:0]  row;
		logic [SYM_W-1:0]  col;
		logic [VAL_W-1:0]  value;
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} q_head_t;

	// Last member sits in the lowest bits
	typedef struct packed {
		logic [VAL_W-1:0] end_state;
		logic [POS_W-1:0] len;
		logic             found;
	} result_t;

endpackage

FILE: hdl/tdfa_ram.sv
// Generic single-port RAM with registered read.
module tdfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write or read one word per enabled cycle
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/tdfa_front.sv
// Input side: accepts beats, classifies the command and drops unused codes.
module tdfa_front (
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [tdfa_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [tdfa_pkg::CMD_W-1:0]      s_tuser,
	input  logic                            q_ready,
	output logic                            push,
	output tdfa_pkg::op_t                   op
);

	logic known;

	assign s_tready = q_ready;

	// Classify the command; the unused code is accepted and dropped
	always_comb begin
		known   = 1'b1;
		op.kind = tdfa_pkg::OP_WRITE;
		// Unpack the payload fields
		op.code  = s_tdata[6:0];
		op.row   = s_tdata[10:7];
		op.col   = s_tdata[17:11];
		op.value = s_tdata[22:18];
		unique case (s_tuser)
			tdfa_pkg::CMD_WRITE: op.kind = tdfa_pkg::OP_WRITE;
			tdfa_pkg::CMD_CHAR:  op.kind = tdfa_pkg::OP_CHAR;
			tdfa_pkg::CMD_START: op.kind = tdfa_pkg::OP_START;
			default:             known   = 1'b0;
		endcase
	end

	assign push = s_tvalid && q_ready && known;

endmodule

FILE: hdl/tdfa_queue.sv
// Short operation queue between the input side and the scan engine.
module tdfa_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tdfa_pkg::op_t     op_in,
	input  logic              pop,
	output tdfa_pkg::q_head_t head,
	output logic              ready
);

	tdfa_pkg::op_t                mem_q [tdfa_pkg::Q_DEPTH];
	logic [tdfa_pkg::Q_AW-1:0]    wr_ptr_q;
	logic [tdfa_pkg::Q_AW-1:0]    rd_ptr_q;
	logic [tdfa_pkg::Q_AW:0]      count_q;

	assign ready      = count_q != (tdfa_pkg::Q_AW + 1)'(tdfa_pkg::Q_DEPTH);
	assign head.valid = count_q != '0;
	assign head.op    = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= op_in;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/tdfa_back.sv
// Scan engine: table lookup stage, DFA step stage and result register.
module tdfa_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tdfa_pkg::q_head_t               head,
	output logic                            pop,
	input  logic [tdfa_pkg::LIM_W-1:0]      scan_limit,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [tdfa_pkg::OUT_DATA_W-1:0] m_tdata
);

	logic                          issue;
	logic                          stall;
	logic                          ram_we;
	logic [tdfa_pkg::TBL_AW-1:0]   ram_addr;
	logic [tdfa_pkg::VAL_W-1:0]    ram_rdata;

	logic                          vld_s2;
	tdfa_pkg::op_t                 op_s2;

	logic [tdfa_pkg::NUM_STATES-1:0] accept_q;
	logic [tdfa_pkg::VAL_W-1:0]    state_q;
	logic [tdfa_pkg::POS_W-1:0]    pos_q;
	logic [tdfa_pkg::POS_W-1:0]    len_q;
	logic                          active_q;

	logic                          ns_dead;
	logic [tdfa_pkg::VAL_W-1:0]    ns;
	logic                          acc;
	logic [tdfa_pkg::POS_W-1:0]    pos_inc;
	logic [tdfa_pkg::POS_W-1:0]    len_nx;
	logic                          stop;
	logic                          char_act;
	logic                          emit;
	logic [tdfa_pkg::VAL_W-1:0]    st_nx;

	logic                          out_vld_q;
	tdfa_pkg::result_t             out_q;

	assign issue = head.valid && !stall;
	assign pop   = issue;

	// Step the DFA on the lookup result of the op in stage 2
	assign ns_dead  = ram_rdata[tdfa_pkg::VAL_W-1];
	assign ns       = ns_dead ? '1 : ram_rdata;
	assign acc      = !ns_dead && accept_q[ns[tdfa_pkg::ROW_W-1:0]];
	assign pos_inc  = pos_q + 1'b1;
	assign len_nx   = acc ? pos_inc : len_q;
	assign stop     = ns_dead
		|| (pos_inc > tdfa_pkg::POS_W'(scan_limit))
		|| (pos_inc >= tdfa_pkg::POS_W'(tdfa_pkg::MAX_LEN));
	assign char_act = vld_s2 && (op_s2.kind == tdfa_pkg::OP_CHAR) && active_q;
	assign emit     = char_act && stop;
	assign stall    = emit && out_vld_q && !m_tready;

	// Forward the state left by stage 2 to the lookup in stage 1
	always_comb begin
		st_nx = state_q;
		if (vld_s2 && (op_s2.kind == tdfa_pkg::OP_START)) begin
			st_nx = '0;
		end else if (char_act) begin
			st_nx = ns;
		end
	end

	// Stage 1 table access
	assign ram_we   = head.op.kind == tdfa_pkg::OP_WRITE;
	assign ram_addr = ram_we ? {head.op.row, head.op.col}
		: {st_nx[tdfa_pkg::ROW_W-1:0], head.op.code};

	tdfa_ram #(
		.WIDTH(tdfa_pkg::VAL_W),
		.DEPTH(tdfa_pkg::TBL_DEPTH)
	) u_table (
		.clk   (clk),
		.en    (issue),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (head.op.value),
		.rdata (ram_rdata)
	);

	// Mirror the accepting marks of column 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accept_q <= '0;
		end else if (issue && ram_we && (head.op.col == '0)) begin
			accept_q[head.op.row] <= head.op.value == tdfa_pkg::ACCEPT_MARK;
		end
	end

	// Advance the op into stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (!stall) begin
			vld_s2 <= head.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			op_s2 <= head.op;
		end
	end

	// Update the scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			pos_q    <= '0;
			len_q    <= '0;
			active_q <= 1'b0;
		end else if (vld_s2 && !stall) begin
			if (op_s2.kind == tdfa_pkg::OP_START) begin
				state_q  <= '0;
				pos_q    <= '0;
				len_q    <= '0;
				active_q <= 1'b1;
			end else if (char_act) begin
				state_q  <= ns;
				pos_q    <= pos_inc;
				len_q    <= len_nx;
				active_q <= !stop;
			end
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit && !stall) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && !stall) begin
			out_q.found     <= len_nx != '0;
			out_q.len       <= len_nx;
			out_q.end_state <= ns;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, out_q};

endmodule

FILE: hdl/table_dfa_longest_match_scanner.sv
// Top level of the table-driven longest-match scanner.
//
// Input stream (s_*): one beat per command, kind in s_tuser: table write,
// character, or start of a new scan. Table writes fill a 16 x 128 transition
// table; column 0 equal to 1 marks a state as accepting. A start beat opens a
// scan in state 0; each character beat steps the DFA. The scan ends when the
// state goes dead or position scan_limit has been processed, and then one
// result beat leaves on m_* with found flag, token length and end state.
// Characters outside a scan are dropped.
// Throughput: one beat per cycle unless a held result stalls the engine,
// set by the single table port, which serves one lookup or one write a
// cycle; the next state is forwarded from the lookup data into the next address.
// After the character beat that ends the scan is accepted, its queue entry is
// written, then the table is read, then the result register is loaded and
// the result beat becomes valid.
// The APB port holds scan_limit at address 0 (reset 17); change it only while
// no scan is running.
// Reset clears the queue, the scan state and the result valid flag; the table
// itself holds no reset value and must be written before use.
// If the result receiver stalls, the engine holds once a second result is
// ready, the four-entry queue fills, and s_tready drops.
module table_dfa_longest_match_scanner (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// [6:0] char_code, [10:7] table_row, [17:11] table_column,
	// [22:18] table_value, [23] zero
	input  logic [23:0] s_tdata,
	// [1:0] cmd
	input  logic [1:0]  s_tuser,
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] token_found, [9:1] token_length, [14:10] end_state, [15] zero
	output logic [15:0] m_tdata,
	// Register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic                            q_ready;
	logic                            push;
	tdfa_pkg::op_t                   op;
	tdfa_pkg::q_head_t               q_head;
	logic                            op_pop;
	logic [tdfa_pkg::LIM_W-1:0]      limit_q;
	logic                            reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2] == 1'b0;

	// Register write and readback
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= tdfa_pkg::LIM_W'(17);
		end else if (psel && penable && pwrite && reg_sel) begin
			limit_q <= pwdata[tdfa_pkg::LIM_W-1:0];
		end
	end

	assign prdata = reg_sel ? {{(32 - tdfa_pkg::LIM_W){1'b0}}, limit_q} : '0;

	tdfa_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_ready  (q_ready),
		.push     (push),
		.op       (op)
	);

	tdfa_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.op_in  (op),
		.pop    (op_pop),
		.head   (q_head),
		.ready  (q_ready)
	);

	tdfa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.pop        (op_pop),
		.scan_limit (limit_q),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	// The engine never takes from an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		op_pop |-> q_head.valid)
		else $error("op taken from empty queue");

	// A token is reported exactly when its length is nonzero
	a_found_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[9:1] != 9'd0)))
		else $error("found flag disagrees with token length");

	// The input side is held off only while the queue holds entries
	a_full_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && !s_tready) |-> q_head.valid)
		else $error("input stalled with empty queue");

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the table-driven longest-match scanner.
module tb_top;
	import tdfa_pkg::*;

	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
	localparam logic [2:0] ADDR_SCAN_LIMIT = 3'd0;
	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_BEATS = 225;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	// Predicts scan results and checks the result beats against them
	class token_scoreboard;
		logic [VAL_W-1:0] next_tbl [NUM_STATES][NUM_SYMBOLS];
		bit loaded [NUM_STATES][NUM_SYMBOLS];
		int dfa_state;
		int char_pos;
		int accept_pos;
		bit scanning;
		int scan_limit;
		result_t pending_tokens[$];
		int mismatches;

		function new();
			dfa_state = 0;
			char_pos = 0;
			accept_pos = -1;
			scanning = 1'b0;
			scan_limit = 17;
			mismatches = 0;
		endfunction

		function int entry(int row, int col);
			return int'($signed(next_tbl[row][col]));
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: %s", msg);
		endfunction

		// Update the table or advance the DFA by one accepted input beat
		function void note_beat(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] code,
				logic [ROW_W-1:0] row, logic [SYM_W-1:0] col, logic [VAL_W-1:0] value);
			result_t tok;
			case (cmd)
			CMD_WRITE: begin
				next_tbl[row][col] = value;
				loaded[row][col] = 1'b1;
			end
			CMD_START: begin
				dfa_state = 0;
				char_pos = 0;
				accept_pos = -1;
				scanning = 1'b1;
			end
			CMD_CHAR: begin
				if (scanning) begin
					// any negative entry is dead
					dfa_state = entry(dfa_state, code);
					if (dfa_state < 0)
						dfa_state = -1;
					if (dfa_state >= 0 && next_tbl[dfa_state][0] == ACCEPT_MARK)
						accept_pos = char_pos;
					char_pos++;
					if (dfa_state < 0 || char_pos > scan_limit || char_pos >= MAX_LEN) begin
						scanning = 1'b0;
						tok.found = (accept_pos >= 0);
						tok.len = POS_W'(accept_pos + 1);
						tok.end_state = VAL_W'(dfa_state);
						pending_tokens.push_back(tok);
					end
				end
			end
			default: ;
			endcase
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] beat);
			result_t got;
			result_t want;
			got = result_t'(beat[$bits(result_t)-1:0]);
			if (pending_tokens.size() == 0) begin
				report($sformatf("result beat %h with none expected", beat));
				return;
			end
			want = pending_tokens.pop_front();
			if (got.found !== want.found || got.len !== want.len ||
					got.end_state !== want.end_state)
				report($sformatf("found/len/end expected %0d/%0d/%0d, got %0d/%0d/%0d",
					want.found, want.len, $signed(want.end_state),
					got.found, got.len, $signed(got.end_state)));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [CMD_W-1:0] s_tuser = CMD_NONE;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	token_scoreboard sb = new();
	idle_mode_t idle_mode = IDLE_NONE;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int beats_sent = 0;
	int quiet = 0;

	table_dfa_longest_match_scanner dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	function automatic int idle_pct(bit rx_side);
		if (idle_mode == IDLE_BOTH)
			return 14;
		if (idle_mode == (rx_side ? IDLE_RECEIVER : IDLE_SENDER))
			return 85;
		return 0;
	endfunction

	// tdata: [6:0] char_code, [10:7] table_row, [17:11] table_column, [22:18] table_value
	function automatic logic [IN_DATA_W-1:0] pack_beat(logic [SYM_W-1:0] code,
			logic [ROW_W-1:0] row, logic [SYM_W-1:0] col, logic [VAL_W-1:0] value);
		return {1'b0, value, col, row, code};
	endfunction

	// Random filler for the fields a command does not use
	function automatic logic [IN_DATA_W-1:0] noise_beat();
		return pack_beat(SYM_W'($urandom), ROW_W'($urandom), SYM_W'($urandom),
			VAL_W'($urandom));
	endfunction

	// Mostly live next states, some dead ones
	function automatic logic [VAL_W-1:0] rand_value();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 80)
			return VAL_W'($urandom_range(0, NUM_STATES - 1));
		if (pick < 93)
			return '1;
		return VAL_W'($urandom);
	endfunction

	// Input side: offer one beat, idle before it as the mode asks
	task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [IN_DATA_W-1:0] data);
		if (cmd == CMD_WRITE || cmd == CMD_START || (cmd == CMD_CHAR && sb.scanning))
			beats_sent++;
		while ($urandom_range(0, 99) < idle_pct(1'b0)) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tuser <= cmd;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_entry(input int row, input int col, input logic [VAL_W-1:0] value);
		send_beat(CMD_WRITE, pack_beat(SYM_W'($urandom), ROW_W'(row), SYM_W'(col), value));
	endtask

	task automatic start_scan();
		send_beat(CMD_START, noise_beat());
	endtask

	task automatic random_write();
		int col;
		logic [VAL_W-1:0] value;
		col = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, NUM_SYMBOLS - 1);
		value = rand_value();
		if (col == 0 && $urandom_range(0, 1) == 1)
			value = ACCEPT_MARK;
		write_entry($urandom_range(0, NUM_STATES - 1), col, value);
	endtask

	// Send a loaded char while scanning (bias 1 favors live, 2 dead), else a noise char
	task automatic send_char(input int bias);
		int opts[$];
		int pref[$];
		int st;
		int c;
		if (!sb.scanning) begin
			send_beat(CMD_CHAR, noise_beat());
			return;
		end
		st = sb.dfa_state;
		// grow the alphabet of this state now and then
		if ($urandom_range(0, 99) < 15)
			write_entry(st, $urandom_range(1, NUM_SYMBOLS - 1), rand_value());
		for (c = 0; c < NUM_SYMBOLS; c++) begin
			if (sb.loaded[st][c]) begin
				opts.push_back(c);
				if ((bias == 1 && sb.entry(st, c) >= 0) || (bias == 2 && sb.entry(st, c) < 0))
					pref.push_back(c);
			end
		end
		if (pref.size() != 0)
			c = pref[$urandom_range(0, pref.size() - 1)];
		else
			c = opts[$urandom_range(0, opts.size() - 1)];
		send_beat(CMD_CHAR, pack_beat(SYM_W'(c), ROW_W'($urandom), SYM_W'($urandom),
			VAL_W'($urandom)));
	endtask

	// Run the current scan to its end
	task automatic end_scan();
		while (sb.scanning)
			send_char(2);
	endtask

	// Hold input until every expected result is out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending_tokens.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic apb_cycle(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ADDR_SCAN_LIMIT;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_scan_limit(input int limit);
		logic [31:0] rd;
		apb_cycle(1'b1, 32'(limit), rd);
		apb_cycle(1'b0, '0, rd);
		if (rd !== 32'(limit))
			sb.report($sformatf("scan_limit read %h after writing %0d", rd, limit));
		sb.scan_limit = limit;
	endtask

	// Mixed traffic: mostly complete scans, plus writes, noise and cut-off scans
	task automatic run_phase(input int target);
		int goal;
		goal = beats_sent + target;
		while (beats_sent < goal) begin
			case ($urandom_range(0, 99)) inside
			[0:64]: begin
				start_scan();
				while (sb.scanning) begin
					if ($urandom_range(0, 99) < 4)
						random_write();
					else
						send_char(($urandom_range(0, 99) < 85) ? 1 : 0);
				end
			end
			[65:79]: begin
				repeat ($urandom_range(1, 4)) random_write();
			end
			[80:91]: begin
				case ($urandom_range(0, 2))
				0: begin
					if (!sb.scanning)
						send_char(0);
				end
				1: begin
					send_beat(CMD_NONE, noise_beat());
				end
				default: begin
					// abandon a running scan with a fresh start
					start_scan();
					repeat ($urandom_range(0, 3)) send_char(1);
					start_scan();
					while (sb.scanning)
						send_char(1);
				end
				endcase
			end
			default: begin
				start_scan();
				repeat ($urandom_range(1, 3)) send_char(0);
			end
			endcase
		end
	endtask

	// Result side: random stalls, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
		end
	end

	// Track accepted input beats
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_beat(s_tuser, s_tdata[6:0], s_tdata[10:7], s_tdata[17:11], s_tdata[22:18]);
	end

	// Check accepted result beats
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] rd;
		int limit_plan[8];
		idle_mode_t mode_plan[8];
		int p;
		int r;

		limit_plan = '{0, 255, 3, 17, 1, 255, 40, 0};
		limit_plan[7] = $urandom_range(2, 254);
		mode_plan = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
			IDLE_BOTH, IDLE_NONE, IDLE_RECEIVER, IDLE_SENDER};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// scan_limit comes out of reset at 17
		apb_cycle(1'b0, '0, rd);
		if (rd !== 32'd17)
			sb.report($sformatf("scan_limit reset value %h", rd));

		// Load the accept column of every state: odd states accept
		for (r = 0; r < NUM_STATES; r++)
			write_entry(r, 0, (r % 2 == 1) ? ACCEPT_MARK : VAL_W'(r));

		// Directed: field extremes, dead entries, idle chars, restarts
		write_entry(0, NUM_SYMBOLS - 1, 5'd15);
		write_entry(15, 42, 5'b11111);
		write_entry(15, NUM_SYMBOLS - 1, 5'b10000);
		send_beat(CMD_CHAR, pack_beat(7'd85, '1, '1, '1));
		send_beat(CMD_NONE, pack_beat('1, '1, '1, '1));
		start_scan();
		send_beat(CMD_CHAR, pack_beat(7'd127, '0, '0, '0));
		send_beat(CMD_CHAR, pack_beat(7'd42, '0, '0, '0));
		start_scan();
		send_beat(CMD_CHAR, pack_beat(7'd0, '1, '1, '1));
		start_scan();
		send_beat(CMD_CHAR, pack_beat(7'd127, '0, '0, '0));
		send_beat(CMD_CHAR, pack_beat(7'd127, '0, '0, '0));
		start_scan();
		write_entry(0, 1, ACCEPT_MARK);
		send_beat(CMD_CHAR, pack_beat(7'd1, '0, '0, '0));
		start_scan();
		write_entry(0, 5, 5'b11111);
		send_beat(CMD_CHAR, pack_beat(7'd5, '0, '0, '0));

		for (p = 0; p < 8; p++) begin
			end_scan();
			wait_drained();
			set_scan_limit(limit_plan[p]);
			idle_mode = mode_plan[p];
			if (p == 0) begin
				// stall the result side while every char ends a scan
				hold_req = 1'b1;
				repeat (40) begin
					start_scan();
					send_char(0);
				end
			end
			run_phase(PHASE_BEATS);
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_tokens.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
